/* hw/rtl/heredoc_token_scanner_macros.svh */
// Assertion macros shared by the heredoc token scanner RTL.
// Depends on a clock named clk and an active-low reset named rst_n in scope.
`ifndef HEREDOC_TOKEN_SCANNER_MACROS_SVH
`define HEREDOC_TOKEN_SCANNER_MACROS_SVH
// Checks that a condition holds at every clock edge out of reset.
`define HDTS_ASSERT(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);
// Checks that a trigger is followed by a condition on the next edge.
`define HDTS_ASSERT_NXT(label, trig, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
    else $error(msg);
`endif

/* hw/rtl/hdts_pkg.sv */
// Shared types, codes and constants of the heredoc token scanner.
// Depends on nothing; hdts_front, hdts_outq, hdts_back and the top import it.
package hdts_pkg;

  localparam int MAX_TAG_LEN_DEF = 255;
  localparam int TAG_DEPTH       = 256;
  localparam int TAG_AW          = 8;
  localparam int OUTQ_DEPTH      = 4;

  localparam logic [7:0] CH_AT     = 8'h40;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_SLASH  = 8'h2f;
  localparam logic [7:0] CH_PIPE   = 8'h7c;
  localparam logic [7:0] CH_DASH   = 8'h2d;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_LF     = 8'h0a;
  localparam logic [7:0] CH_CR     = 8'h0d;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;

  localparam logic [2:0] KIND_NONE   = 3'd0;
  localparam logic [2:0] KIND_OPENER = 3'd1;
  localparam logic [2:0] KIND_BODY   = 3'd2;
  localparam logic [2:0] KIND_CLOSER = 3'd3;
  localparam logic [2:0] KIND_ERROR  = 3'd4;

  typedef enum logic [12:0] {
    M_IDLE  = 13'b0000000000001,
    M_AT    = 13'b0000000000010,
    M_PAREN = 13'b0000000000100,
    M_QTAG  = 13'b0000000001000,
    M_BTAG  = 13'b0000000010000,
    M_AFTQ  = 13'b0000000100000,
    M_FLAGS = 13'b0000001000000,
    M_BREAK = 13'b0000010000000,
    M_LEAD  = 13'b0000100000000,
    M_PIPE  = 13'b0001000000000,
    M_DASH  = 13'b0010000000000,
    M_MATCH = 13'b0100000000000,
    M_REST  = 13'b1000000000000
  } mode_t;

  typedef struct packed {
    logic [7:0] char_code;
    logic       end_of_input;
    logic       opener_allowed;
    logic       blank;
    logic       eol;
    logic       letter;
    logic       tag_char;
  } item_t;

  typedef struct packed {
    logic [2:0]  token_kind;
    logic [31:0] token_start_pos;
    logic [31:0] token_end_pos;
    logic        last_of_run;
  } res_t;

  typedef struct packed {
    logic wr0;
    logic wr1;
    res_t res0;
    res_t res1;
  } res_wr_t;

endpackage

/* hw/rtl/hdts_ram.sv */
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.
module hdts_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

/* hw/rtl/hdts_front.sv */
// Front part: accepts source words, classifies the character, and holds
// them in a two-entry queue for the scanner. Depends on hdts_pkg.
module hdts_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_push,
  output logic               in_full,
  input  logic [7:0]         in_char_code,
  input  logic               in_end_of_input,
  input  logic               in_opener_allowed,
  output logic               q_valid,
  output hdts_pkg::item_t    q_item,
  input  logic               q_take
);
  import hdts_pkg::*;

  item_t      buf_r [2];
  logic       head_r, head_nxt, tail_r, tail_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  item_t      cls;
  logic       push_ok, take_ok;
  logic [7:0] c;

  always_comb begin
    c = in_char_code;
    cls.char_code      = c;
    cls.end_of_input   = in_end_of_input;
    cls.opener_allowed = in_opener_allowed;
    cls.blank          = (c == CH_SPACE) || (c == CH_TAB);
    cls.eol            = (c == CH_LF) || (c == CH_CR);
    cls.letter         = ((c >= 8'h61) && (c <= 8'h7a)) || ((c >= 8'h41) && (c <= 8'h5a));
    cls.tag_char       = cls.letter || ((c >= 8'h30) && (c <= 8'h39)) ||
                         (c == 8'h5f) || (c == CH_DASH);
  end

  assign in_full = (cnt_r == 2'd2);
  assign q_valid = (cnt_r != 2'd0);
  assign q_item  = buf_r[head_r];
  assign push_ok = in_push && !in_full;
  assign take_ok = q_take && q_valid;

  always_comb begin
    head_nxt = head_r ^ take_ok;
    tail_nxt = tail_r ^ push_ok;
    cnt_nxt  = cnt_r + {1'b0, push_ok} - {1'b0, take_ok};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= 1'b0;
      tail_r <= 1'b0;
      cnt_r  <= 2'd0;
    end else begin
      head_r <= head_nxt;
      tail_r <= tail_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_ok) begin
      buf_r[tail_r] <= cls;
    end
  end
endmodule

/* hw/rtl/hdts_outq.sv */
// Result queue: takes up to two result words a cycle from the scanner and
// hands them out one at a time. Depends on hdts_pkg and the macro header.
`include "heredoc_token_scanner_macros.svh"
module hdts_outq (
  input  logic              clk,
  input  logic              rst_n,
  input  hdts_pkg::res_wr_t wr,
  output logic              space2,
  output logic              out_empty,
  input  logic              out_pop,
  output hdts_pkg::res_t    out_res
);
  import hdts_pkg::*;

  res_t       ent_r [OUTQ_DEPTH];
  logic [1:0] head_r, head_nxt, tail_r, tail_nxt;
  logic [2:0] cnt_r, cnt_nxt;
  logic       pop_ok;
  logic [1:0] tail1;

  assign out_empty = (cnt_r == 3'd0);
  assign out_res   = ent_r[head_r];
  assign space2    = (cnt_r <= 3'd2);
  assign pop_ok    = out_pop && !out_empty;
  assign tail1     = tail_r + 2'd1;

  always_comb begin
    head_nxt = head_r + {1'b0, pop_ok};
    tail_nxt = tail_r + {1'b0, wr.wr0} + {1'b0, wr.wr1};
    cnt_nxt  = cnt_r + {2'b0, wr.wr0} + {2'b0, wr.wr1} - {2'b0, pop_ok};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= 2'd0;
      tail_r <= 2'd0;
      cnt_r  <= 3'd0;
    end else begin
      head_r <= head_nxt;
      tail_r <= tail_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr.wr0) begin
      ent_r[tail_r] <= wr.res0;
    end
    if (wr.wr1) begin
      ent_r[tail1] <= wr.res1;
    end
  end

  `HDTS_ASSERT(a_cnt_bound, cnt_r <= 3'd4, "result queue count out of range")
  `HDTS_ASSERT(a_wr_order, !wr.wr1 || wr.wr0, "second result written without the first")
  `HDTS_ASSERT_NXT(a_pop_only, pop_ok && !wr.wr0, cnt_r == $past(cnt_r) - 3'd1,
    "pop without write did not lower the count")
endmodule

/* hw/rtl/hdts_back.sv */
// Back part: scans one classified word a cycle while the result queue has room
// for two, keeps the tag in a RAM, writes result words. Depends on hdts_pkg, hdts_ram.
module hdts_back #(
  parameter int MAX_TAG_LEN = hdts_pkg::MAX_TAG_LEN_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_valid,
  input  hdts_pkg::item_t    q_item,
  output logic               q_take,
  input  logic               space2,
  output hdts_pkg::res_wr_t  wr
);
  import hdts_pkg::*;

  mode_t       mode_r, mode_nxt;
  logic [7:0]  tag_len_r, tag_len_nxt, match_r, match_nxt;
  logic        cr_r, cr_nxt;
  logic [31:0] pos_r, pos_nxt, open_r, open_nxt, body_r, body_nxt, line_r, line_nxt;
  logic        go, we, do_tag, do_aftq, do_fail, do_close;
  logic [7:0]  tag_q, c;
  logic [31:0] pos, p1, fs, fe, ce;
  logic        store_ok;

  hdts_ram #(.WIDTH(8), .DEPTH(TAG_DEPTH)) u_tag (
    .clk(clk), .we(we), .waddr(tag_len_nxt - 8'd1), .wdata(c),
    .raddr(match_nxt), .rdata(tag_q)
  );

  assign go       = q_valid && space2;
  assign q_take   = go;
  assign c        = q_item.char_code;
  assign pos      = pos_r;
  assign p1       = pos_r + 32'd1;
  assign store_ok = (32'(tag_len_r) < 32'(MAX_TAG_LEN));

  always_comb begin
    mode_nxt = mode_r; tag_len_nxt = tag_len_r; match_nxt = match_r; cr_nxt = cr_r;
    pos_nxt = pos_r; open_nxt = open_r; body_nxt = body_r; line_nxt = line_r;
    we = 1'b0; do_tag = 1'b0; do_aftq = 1'b0; do_fail = 1'b0; do_close = 1'b0;
    fs = open_r; fe = p1; ce = p1;
    wr = '0;
    if (go && q_item.end_of_input) begin
      case (mode_r)
        M_AT, M_PAREN, M_QTAG, M_BTAG, M_AFTQ, M_FLAGS: begin
          do_fail = 1'b1; fe = pos;
        end
        M_BREAK: begin
          do_fail = 1'b1; fs = body_r; fe = pos;
        end
        M_LEAD, M_PIPE, M_DASH, M_MATCH, M_REST: begin
          if (mode_r != M_REST && match_r >= tag_len_r) begin
            do_close = 1'b1; ce = pos;
          end else begin
            wr.wr0 = 1'b1;
            wr.res0 = '{KIND_BODY, body_r, pos, 1'b1};
          end
        end
        default: ;
      endcase
      mode_nxt = M_IDLE; tag_len_nxt = 8'd0; match_nxt = 8'd0; cr_nxt = 1'b0;
    end else if (go) begin
      pos_nxt = p1;
      case (mode_r)
        M_IDLE: begin
          if (q_item.opener_allowed && c == CH_AT) begin
            open_nxt = pos; mode_nxt = M_AT;
          end
        end
        M_AT: begin
          if (c == CH_LPAREN) mode_nxt = M_PAREN;
          else do_fail = 1'b1;
        end
        M_PAREN: begin
          if (c == CH_QUOTE) begin
            tag_len_nxt = 8'd0; mode_nxt = M_QTAG;
          end else if (q_item.tag_char && (MAX_TAG_LEN > 0)) begin
            we = 1'b1; tag_len_nxt = 8'd1; mode_nxt = M_BTAG;
          end else do_fail = 1'b1;
        end
        M_QTAG: begin
          if (c == CH_QUOTE) mode_nxt = M_AFTQ;
          else if (!q_item.eol && store_ok) begin
            we = 1'b1; tag_len_nxt = tag_len_r + 8'd1;
          end else do_fail = 1'b1;
        end
        M_BTAG: begin
          if (q_item.tag_char) begin
            if (store_ok) begin
              we = 1'b1; tag_len_nxt = tag_len_r + 8'd1;
            end else do_fail = 1'b1;
          end else do_aftq = 1'b1;
        end
        M_AFTQ: do_aftq = 1'b1;
        M_FLAGS: begin
          if (q_item.letter) ;
          else if (c == CH_RPAREN) begin
            wr.wr0 = 1'b1; wr.res0 = '{KIND_OPENER, open_r, p1, 1'b1};
            body_nxt = p1; cr_nxt = 1'b0; mode_nxt = M_BREAK;
          end else do_fail = 1'b1;
        end
        M_BREAK: begin
          if (c == CH_CR && !cr_r) cr_nxt = 1'b1;
          else if (c == CH_LF) begin
            line_nxt = p1; mode_nxt = M_LEAD; match_nxt = 8'd0; cr_nxt = 1'b0;
          end else begin
            do_fail = 1'b1; fs = body_r;
          end
        end
        M_LEAD: begin
          cr_nxt = 1'b0;
          if (cr_r && c == CH_LF) line_nxt = p1;
          else if (q_item.blank) ;
          else if (c == CH_PIPE) mode_nxt = M_PIPE;
          else if (c == CH_DASH) mode_nxt = M_DASH;
          else do_tag = 1'b1;
        end
        M_PIPE: begin
          if (q_item.blank) ;
          else if (c == CH_DASH) mode_nxt = M_DASH;
          else do_tag = 1'b1;
        end
        M_DASH: begin
          if (!q_item.blank) do_tag = 1'b1;
        end
        M_MATCH: do_tag = 1'b1;
        M_REST: begin
          if (q_item.eol) begin
            line_nxt = p1; mode_nxt = M_LEAD; match_nxt = 8'd0; cr_nxt = (c == CH_CR);
          end
        end
        default: begin
          mode_nxt = M_IDLE; tag_len_nxt = 8'd0; match_nxt = 8'd0; cr_nxt = 1'b0;
        end
      endcase
      if (do_aftq) begin
        if (c == CH_SLASH) mode_nxt = M_FLAGS;
        else if (c == CH_RPAREN) begin
          wr.wr0 = 1'b1; wr.res0 = '{KIND_OPENER, open_r, p1, 1'b1};
          body_nxt = p1; cr_nxt = 1'b0; mode_nxt = M_BREAK;
        end else do_fail = 1'b1;
      end
      if (do_tag) begin
        mode_nxt = M_MATCH;
        if (match_r < tag_len_r) begin
          if (c == tag_q) match_nxt = match_r + 8'd1;
          else if (q_item.eol) begin
            line_nxt = p1; mode_nxt = M_LEAD; match_nxt = 8'd0; cr_nxt = (c == CH_CR);
          end else mode_nxt = M_REST;
        end else if (q_item.blank) ;
        else if (q_item.eol) do_close = 1'b1;
        else mode_nxt = M_REST;
      end
    end
    if (do_fail) begin
      wr.wr0 = 1'b1; wr.res0 = '{KIND_ERROR, fs, fe, 1'b1};
      mode_nxt = M_IDLE; tag_len_nxt = 8'd0; match_nxt = 8'd0; cr_nxt = 1'b0;
    end
    if (do_close) begin
      wr.wr0 = 1'b1; wr.res0 = '{KIND_BODY, body_r, line_r, 1'b0};
      wr.wr1 = 1'b1; wr.res1 = '{KIND_CLOSER, line_r, ce, 1'b1};
      mode_nxt = M_IDLE; tag_len_nxt = 8'd0; match_nxt = 8'd0; cr_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= M_IDLE; tag_len_r <= 8'd0; match_r <= 8'd0; cr_r <= 1'b0;
      pos_r <= 32'd0; open_r <= 32'd0; body_r <= 32'd0; line_r <= 32'd0;
    end else begin
      mode_r <= mode_nxt; tag_len_r <= tag_len_nxt; match_r <= match_nxt; cr_r <= cr_nxt;
      pos_r <= pos_nxt; open_r <= open_nxt; body_r <= body_nxt; line_r <= line_nxt;
    end
  end
endmodule

/* hw/rtl/heredoc_token_scanner.sv */
// Heredoc token scanner: one source character per word in, heredoc tokens out.
// Depends on hdts_pkg, hdts_front, hdts_back, hdts_outq and hdts_ram.
//
// The input channel is a queue: a word is taken when in_push is high and
// in_full is low. Each word carries one character, an end-of-input mark and
// an opener-allowed flag. The result channel is a queue too: the oldest token
// is on the out_ ports while out_empty is low and leaves on out_pop.
// A word waits in the input queue until the scanner takes it, and its results
// wait in the result queue until they reach the head and show on the out_ ports.
// While the result queue has room, the scanner handles one word per cycle; it
// compares one character against one tag byte read from the tag RAM, whose
// registered read address is set in the cycle before, from the next match index.
// A word that causes a body and a closer token writes both in the same cycle.
// The scanner waits while the result queue has fewer than two free entries;
// the two-entry input queue then fills and raises in_full.
// Reset empties both queues and returns the scanner to idle with position
// zero; the tag RAM is not cleared and needs no pass.
module heredoc_token_scanner #(
  parameter int MAX_TAG_LEN = hdts_pkg::MAX_TAG_LEN_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_push,
  output logic        in_full,
  input  logic [7:0]  in_char_code,
  input  logic        in_end_of_input,
  input  logic        in_opener_allowed,
  output logic        out_empty,
  input  logic        out_pop,
  output logic [2:0]  out_token_kind,
  output logic [31:0] out_token_start_pos,
  output logic [31:0] out_token_end_pos,
  output logic        out_last_of_run
);
  import hdts_pkg::*;

  logic    q_valid, q_take, space2;
  item_t   q_item;
  res_wr_t wr;
  res_t    res;

  hdts_front u_front (
    .clk(clk), .rst_n(rst_n), .in_push(in_push), .in_full(in_full),
    .in_char_code(in_char_code), .in_end_of_input(in_end_of_input),
    .in_opener_allowed(in_opener_allowed),
    .q_valid(q_valid), .q_item(q_item), .q_take(q_take)
  );

  hdts_back #(.MAX_TAG_LEN(MAX_TAG_LEN)) u_back (
    .clk(clk), .rst_n(rst_n), .q_valid(q_valid), .q_item(q_item),
    .q_take(q_take), .space2(space2), .wr(wr)
  );

  hdts_outq u_outq (
    .clk(clk), .rst_n(rst_n), .wr(wr), .space2(space2),
    .out_empty(out_empty), .out_pop(out_pop), .out_res(res)
  );

  assign out_token_kind      = res.token_kind;
  assign out_token_start_pos = res.token_start_pos;
  assign out_token_end_pos   = res.token_end_pos;
  assign out_last_of_run     = res.last_of_run;
endmodule
